### rtl/core/noot_pkg.sv
// Shared types, constants and helpers for the note onset/offset tracker.
// No dependencies; every other file of the block but noot_fifo uses this package.
package noot_pkg;

    // Default values of the top-level parameters
    localparam int MIN_NOTE_FRAMES_DFLT  = 3;
    localparam int FRAME_INDEX_BITS_DFLT = 24;

    // Fixed field widths
    localparam int AMP_BITS         = 16;
    localparam int PITCH_BITS       = 7;
    localparam int VEL_BITS         = 7;
    localparam int EVENT_FRAME_BITS = 24;

    // Configuration port
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_PLAY = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_STOP = 1'b1;

    // Threshold reset values, Q2.14 (0.3 and 0.045)
    localparam logic [AMP_BITS-1:0] PLAY_THRESHOLD_RST = 16'd4915;
    localparam logic [AMP_BITS-1:0] STOP_THRESHOLD_RST = 16'd737;

    // Event kinds
    localparam logic EV_NOTE_ON  = 1'b0;
    localparam logic EV_NOTE_OFF = 1'b1;

    // Queue depths (powers of two)
    localparam int FRAME_Q_DEPTH = 4;
    localparam int NOTE_Q_DEPTH  = 2;

    typedef struct packed {
        logic [AMP_BITS-1:0] play;
        logic [AMP_BITS-1:0] stop;
    } t_cfg;

    // One classified frame as it waits for the decision unit
    typedef struct packed {
        logic [AMP_BITS-1:0]   amp;
        logic [PITCH_BITS-1:0] pitch;
        logic                  last;
        logic                  first;
        logic                  long_run;
    } t_frame_entry;

    // Velocity from a Q2.14 peak: min(round(127 * peak), 127)
    function automatic logic [VEL_BITS-1:0] vel_from_peak(input logic [AMP_BITS-1:0] peak);
        logic [23:0] prod;
        logic [9:0]  q;
        prod = {1'b0, peak, 7'b0} - {8'b0, peak} + 24'd8192;
        q    = prod[23:14];
        if (q > 10'd127) begin
            return 7'd127;
        end
        return q[VEL_BITS-1:0];
    endfunction

endpackage

### rtl/core/noot_if.sv
// Valid/ready channel interfaces: analysis frames in, note events out.
// Depends on noot_pkg for the field widths.
interface noot_frame_if;
    logic                            valid;
    logic                            ready;
    logic [noot_pkg::AMP_BITS-1:0]   frame_amplitude;
    logic [noot_pkg::PITCH_BITS-1:0] frame_pitch;
    logic                            frame_last;

    modport source (output valid, output frame_amplitude, output frame_pitch,
                    output frame_last, input ready);
    modport sink   (input valid, input frame_amplitude, input frame_pitch,
                    input frame_last, output ready);
endinterface

interface noot_event_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  event_kind;
    logic [noot_pkg::EVENT_FRAME_BITS-1:0] event_frame;
    logic [noot_pkg::PITCH_BITS-1:0]       event_pitch;
    logic [noot_pkg::VEL_BITS-1:0]         event_velocity;
    logic                                  event_final;

    modport source (output valid, output event_kind, output event_frame,
                    output event_pitch, output event_velocity, output event_final,
                    input ready);
    modport sink   (input valid, input event_kind, input event_frame,
                    input event_pitch, input event_velocity, input event_final,
                    output ready);
endinterface

### rtl/core/note_onset_offset_tracker_unit.sv
// Note tracker top: front end, frame queue, decision unit, note queue, event output.
// Order: a note-on is offered once the window decision that ends its note has written the note queue;
// a frame passes through the frame queue before the decision unit takes it.
// Throughput: one frame per cycle while the note queue has room and no flush runs; the last
// frame of a stream starts a flush of the window. Each note takes two output transactions.
// Synchronous active-low reset empties the queues, clears the stream state, restores 0.3/0.045.
module note_onset_offset_tracker_unit #(
    parameter int MIN_NOTE_FRAMES  = noot_pkg::MIN_NOTE_FRAMES_DFLT,
    parameter int FRAME_INDEX_BITS = noot_pkg::FRAME_INDEX_BITS_DFLT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [noot_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [noot_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    noot_frame_if.sink                          i_frame,
    noot_event_if.source                        o_event
);
    import noot_pkg::*;

    localparam int IDX  = FRAME_INDEX_BITS;
    localparam int FE_W = $bits(t_frame_entry);
    localparam int FQ_W = FE_W + IDX;
    localparam int NQ_W = 2 * IDX + PITCH_BITS + AMP_BITS;

    t_cfg            r_cfg;
    logic            f_push;
    t_frame_entry    f_entry;
    logic [IDX-1:0]  f_count;
    logic            fq_full;
    logic            fq_empty;
    logic            fq_pop;
    logic [FQ_W-1:0] fq_data;
    t_frame_entry    q_entry;
    logic [IDX-1:0]  q_count;
    logic            nq_push;
    logic [NQ_W-1:0] nq_wdata;
    logic            nq_full;
    logic            nq_empty;
    logic            nq_pop;
    logic [NQ_W-1:0] nq_rdata;

    // Write threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.play <= PLAY_THRESHOLD_RST;
            r_cfg.stop <= STOP_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_PLAY: r_cfg.play <= i_cfg_data[AMP_BITS-1:0];
                CFG_IDX_STOP: r_cfg.stop <= i_cfg_data[AMP_BITS-1:0];
                default: ;
            endcase
        end
    end

    noot_front #(
        .MIN_NOTE_FRAMES (MIN_NOTE_FRAMES),
        .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (i_frame),
        .i_q_full(fq_full),
        .o_push  (f_push),
        .o_entry (f_entry),
        .o_count (f_count)
    );

    noot_fifo #(
        .WIDTH(FQ_W),
        .DEPTH(FRAME_Q_DEPTH)
    ) u_frame_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_data ({f_entry, f_count}),
        .o_full (fq_full),
        .i_pop  (fq_pop),
        .o_data (fq_data),
        .o_empty(fq_empty)
    );

    assign q_entry = fq_data[FQ_W-1 -: FE_W];
    assign q_count = fq_data[IDX-1:0];

    noot_back #(
        .MIN_NOTE_FRAMES (MIN_NOTE_FRAMES),
        .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_frame_valid(!fq_empty),
        .i_entry      (q_entry),
        .i_count      (q_count),
        .o_frame_pop  (fq_pop),
        .i_note_full  (nq_full),
        .o_note_push  (nq_push),
        .o_note       (nq_wdata)
    );

    noot_fifo #(
        .WIDTH(NQ_W),
        .DEPTH(NOTE_Q_DEPTH)
    ) u_note_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (nq_push),
        .i_data (nq_wdata),
        .o_full (nq_full),
        .i_pop  (nq_pop),
        .o_data (nq_rdata),
        .o_empty(nq_empty)
    );

    noot_emit #(
        .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
    ) u_emit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_note (nq_rdata),
        .i_empty(nq_empty),
        .o_pop  (nq_pop),
        .o_event(o_event)
    );
endmodule

### rtl/core/noot_fifo.sv
// Small synchronous FIFO used for the frame queue and the note queue.
// Standalone; DEPTH must be a power of two of at least two.
module noot_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AB = $clog2(DEPTH);
    localparam int CB = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AB-1:0]    r_wr;
    logic [AB-1:0]    r_rd;
    logic [CB-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CB'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + AB'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + AB'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CB'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CB'(1);
            end
        end
    end

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

### rtl/core/noot_front.sv
// Front end: accepts frames, marks stream boundaries and numbers the frames.
// Depends on noot_pkg and noot_frame_if; feeds the frame queue.
module noot_front #(
    parameter int MIN_NOTE_FRAMES  = noot_pkg::MIN_NOTE_FRAMES_DFLT,
    parameter int FRAME_INDEX_BITS = noot_pkg::FRAME_INDEX_BITS_DFLT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    noot_frame_if.sink                  i_frame,
    input  logic                        i_q_full,
    output logic                        o_push,
    output noot_pkg::t_frame_entry      o_entry,
    output logic [FRAME_INDEX_BITS-1:0] o_count
);
    import noot_pkg::*;

    localparam int IDX = FRAME_INDEX_BITS;

    logic           r_in_stream;
    logic [IDX-1:0] r_count;
    logic           r_long;
    logic           first;
    logic [IDX-1:0] n_count;
    logic           n_long;

    assign i_frame.ready = !i_q_full;
    assign o_push        = i_frame.valid && !i_q_full;

    // Classify the frame: start of stream, position, stream long enough
    always_comb begin
        first   = !r_in_stream;
        n_count = (first ? '0 : r_count) + IDX'(1);
        n_long  = (!first && r_long) || (n_count >= IDX'(MIN_NOTE_FRAMES));
    end

    assign o_entry.amp      = i_frame.frame_amplitude;
    assign o_entry.pitch    = i_frame.frame_pitch;
    assign o_entry.last     = i_frame.frame_last;
    assign o_entry.first    = first;
    assign o_entry.long_run = n_long;
    assign o_count          = n_count;

    // Track the stream position across transactions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_stream <= 1'b0;
            r_count     <= '0;
            r_long      <= 1'b0;
        end else if (o_push) begin
            r_in_stream <= !i_frame.frame_last;
            r_count     <= n_count;
            r_long      <= n_long;
        end
    end
endmodule

### rtl/core/noot_back.sv
// Decision unit: lookahead window, note state and one frame decision per cycle while the note queue has room.
// Depends on noot_pkg; reads the frame queue and writes the note queue.
module noot_back #(
    parameter int MIN_NOTE_FRAMES  = noot_pkg::MIN_NOTE_FRAMES_DFLT,
    parameter int FRAME_INDEX_BITS = noot_pkg::FRAME_INDEX_BITS_DFLT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  noot_pkg::t_cfg              i_cfg,
    input  logic                        i_frame_valid,
    input  noot_pkg::t_frame_entry      i_entry,
    input  logic [FRAME_INDEX_BITS-1:0] i_count,
    output logic                        o_frame_pop,
    input  logic                        i_note_full,
    output logic                        o_note_push,
    output logic [2*FRAME_INDEX_BITS+noot_pkg::PITCH_BITS+noot_pkg::AMP_BITS-1:0] o_note
);
    import noot_pkg::*;

    localparam int M   = MIN_NOTE_FRAMES;
    localparam int IDX = FRAME_INDEX_BITS;
    localparam int FB  = $clog2(M + 1);
    localparam int JB  = $clog2(M);

    // Window and note state
    logic [AMP_BITS-1:0]   r_amp   [M];
    logic [PITCH_BITS-1:0] r_pitch [M];
    logic [FB-1:0]         r_fill;
    logic [PITCH_BITS-1:0] r_cur;
    logic [AMP_BITS-1:0]   r_peak;
    logic [IDX-1:0]        r_start;
    logic [IDX-1:0]        r_count;
    logic                  r_long;
    logic                  r_playing;
    logic                  r_will_play;
    logic                  r_will_stop;
    logic                  r_emitted;
    logic                  r_flush;

    logic [AMP_BITS-1:0]   n_amp   [M];
    logic [PITCH_BITS-1:0] n_pitch [M];
    logic [FB-1:0]         n_fill;
    logic [PITCH_BITS-1:0] n_cur;
    logic [AMP_BITS-1:0]   n_peak;
    logic [IDX-1:0]        n_start;
    logic [IDX-1:0]        n_count;
    logic                  n_long;
    logic                  n_playing;
    logic                  n_will_play;
    logic                  n_will_stop;
    logic                  n_emitted;
    logic                  n_flush;

    // Window as seen by this cycle's decision
    logic [AMP_BITS-1:0]   w_amp   [M];
    logic [PITCH_BITS-1:0] w_pitch [M];
    logic [FB-1:0]         e_fill;
    logic [FB-1:0]         v_fill;
    logic [IDX-1:0]        v_count;
    logic                  v_long;
    logic [PITCH_BITS-1:0] v_cur;
    logic [AMP_BITS-1:0]   v_peak;
    logic [IDX-1:0]        v_start;
    logic                  v_playing;
    logic                  v_will_play;
    logic                  v_will_stop;
    logic                  v_emitted;
    logic                  lk;

    logic                  go;
    logic                  take;
    logic                  dec;

    // Decision terms
    logic                  same0;
    logic                  found;
    logic [JB-1:0]         j_fnd;
    logic                  bridge;
    logic                  same;
    logic [JB-1:0]         j_sel;
    logic [AMP_BITS-1:0]   amp_j;
    logic [PITCH_BITS-1:0] pitch_j;
    logic [IDX-1:0]        head;
    logic [IDX-1:0]        at;
    logic                  near_end;
    logic [AMP_BITS:0]     thr_sum;
    logic                  louder;
    logic                  quiet;
    logic [AMP_BITS-1:0]   peak1;
    logic                  to_play;
    logic                  to_stop;
    logic                  wp1;
    logic                  ws1;
    logic [PITCH_BITS-1:0] cur1;
    logic [IDX-1:0]        start1;
    logic [IDX-1:0]        dur;
    logic                  emit;

    assign go          = !i_note_full;
    assign take        = i_frame_valid && !r_flush && go;
    assign o_frame_pop = take;

    // Build the view: stored window during a flush, else the new frame pushed in
    always_comb begin
        w_amp       = r_amp;
        w_pitch     = r_pitch;
        e_fill      = r_fill;
        v_fill      = r_fill;
        v_count     = r_count;
        v_long      = r_long;
        v_cur       = r_cur;
        v_peak      = r_peak;
        v_start     = r_start;
        v_playing   = r_playing;
        v_will_play = r_will_play;
        v_will_stop = r_will_stop;
        v_emitted   = r_emitted;
        lk          = 1'b1;
        if (!r_flush) begin
            lk = i_entry.last;
            if (i_entry.first) begin
                e_fill      = '0;
                v_cur       = i_entry.pitch;
                v_peak      = i_entry.amp;
                v_start     = '0;
                v_playing   = 1'b0;
                v_will_play = 1'b0;
                v_will_stop = 1'b0;
                v_emitted   = 1'b0;
            end
            for (int i = 0; i < M; i++) begin
                if (FB'(i) == e_fill) begin
                    w_amp[i]   = i_entry.amp;
                    w_pitch[i] = i_entry.pitch;
                end
            end
            v_fill  = e_fill + FB'(1);
            v_count = i_count;
            v_long  = i_entry.long_run;
        end
    end

    assign dec = r_flush ? go
                         : (take && (lk ? (v_fill >= FB'(2)) : (v_fill == FB'(M))));

    // Pick the frame to decide: the head, or a bridged frame with the held pitch
    always_comb begin
        same0 = (w_pitch[1] == v_cur);
        found = 1'b0;
        j_fnd = '0;
        for (int i = 2; i < M; i++) begin
            if (!found && (FB'(i) < v_fill) && (!lk || (FB'(i + 1) < v_fill)) &&
                (w_amp[i] >= i_cfg.stop) && (w_pitch[i] == v_cur)) begin
                found = 1'b1;
                j_fnd = JB'(i);
            end
        end
        bridge   = !same0 && v_playing && found;
        same     = same0 || bridge;
        j_sel    = bridge ? j_fnd : '0;
        amp_j    = w_amp[j_sel];
        pitch_j  = w_pitch[j_sel];
        head     = v_count - IDX'(v_fill);
        at       = head + IDX'(j_sel);
        near_end = lk && v_long && ((v_fill - FB'(j_sel)) <= FB'(M));
    end

    // Note start/stop rules with hysteresis
    always_comb begin
        thr_sum = {1'b0, i_cfg.play} + {1'b0, i_cfg.stop};
        louder  = !v_will_stop && (amp_j > v_peak);
        quiet   = !v_will_stop && !louder && !v_playing &&
                  ({amp_j, 1'b0} < thr_sum) && !near_end;
        peak1   = louder ? amp_j : v_peak;
        to_play = !v_will_play && (peak1 >= i_cfg.play) &&
                  (!v_emitted || !v_playing || !same);
        to_stop = v_playing && (((amp_j < i_cfg.stop) && same) || near_end ||
                  (!same && (w_amp[1] > i_cfg.play)));
        ws1     = v_will_stop || to_stop;
        wp1     = v_will_play || to_play;
        cur1    = to_play ? pitch_j : v_cur;
        start1  = (to_play && !v_emitted) ? at : v_start;
        dur     = at - start1;
        emit    = !quiet && wp1 && ws1 && (dur > IDX'(M));
    end

    // Next state
    always_comb begin
        n_amp       = r_amp;
        n_pitch     = r_pitch;
        n_fill      = r_fill;
        n_cur       = r_cur;
        n_peak      = r_peak;
        n_start     = r_start;
        n_count     = r_count;
        n_long      = r_long;
        n_playing   = r_playing;
        n_will_play = r_will_play;
        n_will_stop = r_will_stop;
        n_emitted   = r_emitted;
        n_flush     = r_flush;
        if (take || dec) begin
            n_amp       = w_amp;
            n_pitch     = w_pitch;
            n_fill      = v_fill;
            n_cur       = v_cur;
            n_peak      = v_peak;
            n_start     = v_start;
            n_count     = v_count;
            n_long      = v_long;
            n_playing   = v_playing;
            n_will_play = v_will_play;
            n_will_stop = v_will_stop;
            n_emitted   = v_emitted;
        end
        if (dec) begin
            // drop the decided frame and any skipped ones
            for (int i = 0; i < M; i++) begin
                for (int k = 1; i + k < M; k++) begin
                    if (j_sel == JB'(k - 1)) begin
                        n_amp[i]   = w_amp[i + k];
                        n_pitch[i] = w_pitch[i + k];
                    end
                end
            end
            n_fill = v_fill - FB'(j_sel) - FB'(1);
            if (quiet) begin
                n_start = at;
            end else begin
                n_peak      = peak1;
                n_will_stop = ws1;
                n_will_play = wp1;
                n_cur       = cur1;
                n_start     = start1;
                if (to_play) begin
                    n_playing = 1'b1;
                end else if (to_stop && !v_will_stop) begin
                    n_playing = 1'b0;
                end
                if (wp1 && ws1) begin
                    n_will_play = 1'b0;
                    n_will_stop = 1'b0;
                    if (emit) begin
                        n_emitted = 1'b1;
                        n_start   = at + IDX'(1);
                        n_peak    = '0;
                    end
                end
            end
        end
        // end of stream: keep flushing until fewer than two frames remain
        if ((take || dec) && lk) begin
            n_flush = (n_fill >= FB'(2));
            if (n_fill < FB'(2)) begin
                n_fill = '0;
            end
        end
    end

    assign o_note_push = dec && emit;
    assign o_note      = {start1, at, cur1, peak1};

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_flush     <= 1'b0;
            r_playing   <= 1'b0;
            r_will_play <= 1'b0;
            r_will_stop <= 1'b0;
            r_emitted   <= 1'b0;
            r_long      <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_flush     <= n_flush;
            r_playing   <= n_playing;
            r_will_play <= n_will_play;
            r_will_stop <= n_will_stop;
            r_emitted   <= n_emitted;
            r_long      <= n_long;
        end
    end

    // Hold window and note payload
    always_ff @(posedge i_clk) begin
        r_amp   <= n_amp;
        r_pitch <= n_pitch;
        r_cur   <= n_cur;
        r_peak  <= n_peak;
        r_start <= n_start;
        r_count <= n_count;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FB'(M - 1))
        else $error("lookahead fill exceeds window depth");
    a_flush_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> (r_fill >= FB'(2)))
        else $error("flush running with fewer than two frames");
    a_emit_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_note_push |=> (!r_will_play && !r_will_stop))
        else $error("play/stop flags not cleared after a note");
`endif
endmodule

### rtl/core/noot_emit.sv
// Event output: turns each finished note into a note-on and a note-off event.
// Depends on noot_pkg and noot_event_if; reads the note queue.
module noot_emit #(
    parameter int FRAME_INDEX_BITS = noot_pkg::FRAME_INDEX_BITS_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [2*FRAME_INDEX_BITS+noot_pkg::PITCH_BITS+noot_pkg::AMP_BITS-1:0] i_note,
    input  logic        i_empty,
    output logic        o_pop,
    noot_event_if.source o_event
);
    import noot_pkg::*;

    localparam int IDX = FRAME_INDEX_BITS;

    logic                  r_phase;
    logic [IDX-1:0]        start_f;
    logic [IDX-1:0]        end_f;
    logic [PITCH_BITS-1:0] pitch;
    logic [AMP_BITS-1:0]   peak;
    logic                  xfer;

    function automatic logic [EVENT_FRAME_BITS-1:0] fit_frame(input logic [IDX-1:0] x);
        logic [31:0] wide;
        wide = 32'(x);
        return wide[EVENT_FRAME_BITS-1:0];
    endfunction

    assign {start_f, end_f, pitch, peak} = i_note;

    // Present note-on first, then note-off, from the queue head
    assign o_event.valid          = !i_empty;
    assign o_event.event_kind     = r_phase ? EV_NOTE_OFF : EV_NOTE_ON;
    assign o_event.event_frame    = r_phase ? fit_frame(end_f) : fit_frame(start_f);
    assign o_event.event_pitch    = pitch;
    assign o_event.event_velocity = r_phase ? '0 : vel_from_peak(peak);
    assign o_event.event_final    = r_phase;

    assign xfer  = o_event.valid && o_event.ready;
    assign o_pop = xfer && r_phase;

    // Toggle between the two halves of a note
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (xfer) begin
            r_phase <= !r_phase;
        end
    end

`ifndef SYNTHESIS
    a_pair_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer && !r_phase) |=> (o_event.valid && r_phase))
        else $error("note-off lost after note-on transaction");
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && !o_event.ready) |=> o_event.valid)
        else $error("event valid dropped while waiting");
    a_hold_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event.valid && !o_event.ready) |=>
        $stable({o_event.event_kind, o_event.event_frame, o_event.event_pitch,
                 o_event.event_velocity, o_event.event_final}))
        else $error("event payload changed while waiting");
`endif
endmodule
